FILE: design/bba_pkg.sv
package bba_pkg;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADSIZE = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [9:0]  block_index;
    logic [10:0] block_count;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] granted_block;
  } rsp_t;

endpackage

FILE: design/bba_ram.sv
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/buddy_block_allocator.sv
// Buddy allocator over block indices.
// Channels: req (valid/ready) carries cmd, block_index, block_count; rsp
// (valid/ready) returns status and granted_block, one result per request;
// cfg (valid/ready) writes managed_blocks, taken in any cycle.
// One request at a time: req_ready is high only when the sequencer is idle
// and the result register is empty, so the next request can be taken the
// cycle after the result transaction. Each list step is one read of the
// link RAM, which has a registered read. Init counts the levels, then
// places at most one block per level, largest first; alloc scans upward
// for a nonempty level and splits down to the target one level at a time;
// free walks each level's list for the buddy, unlinks it, merges upward
// and then pushes the merged block. Rejected requests go straight to the
// result register. The link RAM read port sets the pace of a free over a
// long list.
// Reset clears heads to empty, level count to zero, managed_blocks to
// NUM_BLOCKS (truncated to 11 bits); the link RAM is not cleared.
// When the receiver stalls, the result stays in rsp and no new request
// is taken until it is delivered.
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = 1024,
  parameter int NUM_LEVELS = 11
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int LW = AW + 1;             // link width, NIL = NUM_BLOCKS
  localparam int VW = $clog2(NUM_LEVELS + 1);
  localparam int SW = $clog2(NUM_BLOCKS + 1) + 1;  // walk step counter
  localparam logic [LW-1:0] NIL = LW'(NUM_BLOCKS);

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT_CLR, S_INIT_LVL,
    S_AL_SCAN, S_AL_RD, S_AL_POP, S_AL_SPL1, S_AL_SPL2,
    S_FR_LVL, S_FR_RD, S_FR_CHK, S_FR_RDC, S_FR_UNL, S_FR_CLR, S_FR_PUSH,
    S_DONE
  } state_t;

  state_t            state;
  logic [10:0]       managed_blocks;
  logic [LW-1:0]     level_heads [NUM_LEVELS];
  logic [VW-1:0]     level_count;
  logic [VW-1:0]     lvl, scan;
  logic [LW:0]       n;          // remaining init blocks
  logic [LW-1:0]     pos, blk, cur, prev, tmp;
  logic [SW-1:0]     steps;
  logic [1:0]        st;
  logic [AW-1:0]     grant;

  // link RAM
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [LW-1:0]     wdata, rdata;

  bba_ram #(.WIDTH(LW), .DEPTH(NUM_BLOCKS)) u_links (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign req_ready = (state == S_IDLE) && !rsp_valid;
  assign cfg_ready = 1'b1;

  // level of block_count rounded up; pow2 check
  logic [4:0]  req_lvl;
  logic        req_pow2;
  logic [10:0] cnt_m1;
  always_comb begin
    cnt_m1 = req.block_count - 11'd1;
    req_lvl = 5'd0;
    for (int i = 0; i < 11; i++) begin
      if (cnt_m1[i]) begin
        req_lvl = 5'(i + 1);
      end
    end
    req_pow2 = (req.block_count != 11'd0) && ((req.block_count & cnt_m1) == 11'd0);
  end

  logic [LW:0] sz_init;
  logic [LW-1:0] bsize;          // 1 << lvl
  logic [LW-1:0] lo, hi;
  logic          is_buddy;
  always_comb begin
    sz_init = (LW+1)'(1) << (lvl - VW'(1));
    bsize   = LW'(1) << lvl;
    lo = (cur < blk) ? cur : blk;
    hi = (cur < blk) ? blk : cur;
    is_buddy = (lo + bsize == hi) && ((lo & ((bsize << 1) - LW'(1))) == '0);
  end

  // write port and read address are set combinationally from registers
  // in the states that need them
  always_comb begin
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    unique case (state)
      S_INIT_LVL: begin
        if (lvl != '0 && n >= sz_init) begin
          we = 1'b1; waddr = AW'(pos); wdata = NIL;
        end
      end
      S_AL_RD:   raddr = AW'(tmp);
      S_AL_SPL1: begin
        // split only; a plain pop leaves the links alone
        if (scan != lvl) begin
          we = 1'b1; waddr = AW'(cur); wdata = cur + (LW'(1) << (scan - VW'(1)));
        end
      end
      S_AL_SPL2: begin
        we = 1'b1; waddr = AW'(cur + (LW'(1) << (scan - VW'(1))));
        wdata = prev;
      end
      S_FR_CHK:  raddr = AW'(cur);  // next link, used if no buddy here
      S_FR_RDC:  raddr = AW'(cur);
      S_FR_UNL: begin
        if (prev < NIL) begin
          we = 1'b1; waddr = AW'(prev); wdata = rdata;
        end
      end
      S_FR_CLR: begin
        we = 1'b1; waddr = AW'(cur); wdata = NIL;
      end
      S_FR_PUSH: begin
        we = 1'b1; waddr = AW'(blk); wdata = level_heads[lvl];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      managed_blocks <= 11'(NUM_BLOCKS);
      level_count <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        level_heads[i] <= NIL;
      end
    end else begin
      if (cfg_valid) begin
        managed_blocks <= cfg_data;
      end
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            st <= ST_BADSIZE; grant <= '0;
            blk <= LW'(req.block_index);
            unique case (cmd_t'(req.cmd))
              CMD_INIT: begin
                n <= (managed_blocks > 11'(NUM_BLOCKS)) ? (LW+1)'(NUM_BLOCKS)
                                                       : (LW+1)'(managed_blocks);
                lvl <= '0;
                state <= S_INIT_CLR;
              end
              CMD_ALLOC: begin
                lvl <= VW'(req_lvl);
                if (req.block_count == '0 || req_lvl >= 5'(level_count)) begin
                  state <= S_DONE;
                end else begin
                  state <= S_AL_SCAN;
                end
              end
              CMD_FREE: begin
                lvl <= VW'(req_lvl);
                if (!req_pow2 || req_lvl >= 5'(level_count) ||
                    (12'(req.block_index) + 12'(req.block_count)) >
                    12'(NUM_BLOCKS)) begin
                  state <= S_DONE;
                end else begin
                  state <= S_FR_LVL;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        // count levels: lvl = bit length of n, capped
        S_INIT_CLR: begin
          if (lvl < VW'(NUM_LEVELS) && (n >> lvl) != '0) begin
            lvl <= lvl + VW'(1);
          end else begin
            level_count <= lvl;
            pos <= '0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
              level_heads[i] <= NIL;
            end
            state <= S_INIT_LVL;
          end
        end
        S_INIT_LVL: begin
          if (lvl == '0) begin
            st <= ST_OK;
            state <= S_DONE;
          end else begin
            if (n >= sz_init) begin
              level_heads[lvl - VW'(1)] <= pos;
              n <= n - sz_init;
              pos <= pos + LW'(sz_init);
            end
            lvl <= lvl - VW'(1);
          end
        end
        // alloc: lvl is target; scan finds first nonempty >= lvl
        S_AL_SCAN: begin
          if (level_heads[lvl] < NIL) begin
            tmp <= level_heads[lvl];
            state <= S_AL_RD;
            scan <= lvl;
          end else begin
            scan <= lvl + VW'(1);
            state <= S_AL_POP;
          end
        end
        S_AL_POP: begin
          if (scan >= level_count) begin
            st <= ST_NOSPACE;
            state <= S_DONE;
          end else if (level_heads[scan] < NIL) begin
            cur <= level_heads[scan];
            tmp <= level_heads[scan];
            prev <= level_heads[scan - VW'(1)];
            state <= S_AL_RD;
          end else begin
            scan <= scan + VW'(1);
          end
        end
        S_AL_RD: state <= S_AL_SPL1;  // read issued, data next cycle
        S_AL_SPL1: begin
          if (scan == lvl) begin
            // pop granted block
            level_heads[lvl] <= rdata;
            grant <= AW'(tmp);
            st <= ST_OK;
            state <= S_DONE;
          end else begin
            level_heads[scan] <= rdata;
            level_heads[scan - VW'(1)] <= cur;
            state <= S_AL_SPL2;
          end
        end
        S_AL_SPL2: begin
          state <= S_AL_SCAN;
        end
        // free: per level, walk list looking for buddy
        S_FR_LVL: begin
          prev <= NIL;
          steps <= '0;
          if (lvl + VW'(1) < level_count) begin
            cur <= level_heads[lvl];
            state <= S_FR_CHK;
          end else begin
            state <= S_FR_PUSH;
          end
        end
        S_FR_CHK: begin
          if (cur >= NIL || steps >= SW'(NUM_BLOCKS)) begin
            state <= S_FR_PUSH;
          end else if (is_buddy) begin
            state <= S_FR_RDC;
          end else begin
            state <= S_FR_RD;
          end
        end
        // link of cur was read in S_FR_CHK
        S_FR_RD: begin
          prev <= cur;
          cur <= rdata;
          steps <= steps + SW'(1);
          state <= S_FR_CHK;
        end
        S_FR_RDC: state <= S_FR_UNL;
        S_FR_UNL: begin
          if (prev >= NIL) begin
            level_heads[lvl] <= rdata;
          end
          if (cur < blk) begin
            blk <= cur;
          end
          lvl <= lvl + VW'(1);
          state <= S_FR_CLR;
        end
        S_FR_CLR: state <= S_FR_LVL;  // buddy link cleared
        S_FR_PUSH: begin
          level_heads[lvl] <= blk;
          st <= ST_OK;
          state <= S_DONE;
        end
        S_DONE: begin
          rsp_valid <= 1'b1;
          rsp.status <= st;
          rsp.granted_block <= (st == ST_OK) ? grant : '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/bba_checker.sv
module bba_props
  import bba_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("request taken with result pending");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.granted_block == '0)
    else $error("grant on failure");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status != ST_RSVD) else $error("bad status");

endmodule

bind buddy_block_allocator bba_props u_chk (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
  .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);
